@@ rtl/c6502alu_pkg.sv @@
// c6502alu_pkg: operation codes, configuration register indexes and reset
// values for the 6502 ALU core. No dependencies; imported by the ALU core.
`default_nettype none

package c6502alu_pkg;

	// Operation codes of the opcode field
	typedef enum logic [4:0] {
		OP_ORA = 5'd0,
		OP_AND = 5'd1,
		OP_EOR = 5'd2,
		OP_ADC = 5'd3,
		OP_SBC = 5'd4,
		OP_CMP = 5'd5,
		OP_BIT = 5'd6,
		OP_ASL = 5'd7,
		OP_LSR = 5'd8,
		OP_ROL = 5'd9,
		OP_ROR = 5'd10,
		OP_INC = 5'd11,
		OP_DEC = 5'd12,
		OP_ANC = 5'd13,
		OP_ALR = 5'd14,
		OP_ARR = 5'd15,
		OP_SBX = 5'd16,
		OP_ANE = 5'd17,
		OP_LXA = 5'd18,
		OP_SLO = 5'd19,
		OP_RLA = 5'd20,
		OP_SRE = 5'd21,
		OP_RRA = 5'd22,
		OP_DCP = 5'd23,
		OP_ISC = 5'd24
	} op_t;

	localparam int unsigned OP_W  = 5;
	localparam int unsigned DW    = 8;
	localparam int unsigned CFG_W = 1;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] CFG_ANE_MAGIC = 1'b0;
	localparam logic [CFG_W-1:0] CFG_LXA_MAGIC = 1'b1;

	localparam logic [DW-1:0] ANE_MAGIC_RST = 8'hEF;
	localparam logic [DW-1:0] LXA_MAGIC_RST = 8'hEE;

endpackage

`default_nettype wire

@@ rtl/cpu6502_alu_with_bcd_core.sv @@
// cpu6502_alu_with_bcd_core: 8-bit 6502 ALU with NMOS decimal mode and the
// undocumented combined operations. Depends on c6502alu_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready with the opcode, A (or the compared
//   register), X, the operand byte and the C, D and V flags. Each request
//   yields one result on out_valid/out_ready: new A, new X, the write-back
//   byte of read-modify-write operations and the N, Z, C, V flags.
//   The input register takes the request at the accepting edge, and the
//   result register loads the ALU output and raises out_valid once it is
//   free to advance. Throughput is one request per cycle while out_ready
//   stays high; the whole operation is a single pass through the ALU
//   between the two registers.
//   When the receiver holds out_ready low, the result register holds and
//   the input register still takes one more request; in_ready drops only
//   when both registers are full.
//   The ANE and LXA constants sit on cfg_we/cfg_index/cfg_wdata, written
//   with no read-back. Reset empties the pipeline and sets them to 0xEF
//   and 0xEE.
`default_nettype none

module cpu6502_alu_with_bcd_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [c6502alu_pkg::OP_W-1:0]    opcode,
	input  wire  [c6502alu_pkg::DW-1:0]      acc_in,
	input  wire  [c6502alu_pkg::DW-1:0]      index_x,
	input  wire  [c6502alu_pkg::DW-1:0]      operand,
	input  wire                              carry_in,
	input  wire                              decimal_mode,
	input  wire                              overflow_in,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [c6502alu_pkg::DW-1:0]      acc_out,
	output logic [c6502alu_pkg::DW-1:0]      x_out,
	output logic [c6502alu_pkg::DW-1:0]      write_back,
	output logic                             carry_out,
	output logic                             zero_out,
	output logic                             negative_out,
	output logic                             overflow_out,
	input  wire                              cfg_we,
	input  wire  [c6502alu_pkg::CFG_W-1:0]   cfg_index,
	input  wire  [c6502alu_pkg::DW-1:0]      cfg_wdata
);
	import c6502alu_pkg::*;

	logic [DW-1:0] ane_magic_q, lxa_magic_q;

	// input register
	logic          vld_s1;
	logic [OP_W-1:0] op_s1;
	logic [DW-1:0] a_s1, x_s1, m_s1;
	logic          c_s1, d_s1, v_s1;

	// result register
	logic          vld_s2;
	logic [DW-1:0] acc_s2, x_s2, wb_s2;
	logic          c_s2, z_s2, n_s2, v_s2;

	logic adv_s2;

	// ALU results
	logic [DW-1:0] r_acc, r_x, r_wb;
	logic          r_c, r_z, r_n, r_v;

	// shared adder and subtractor operands
	logic [DW-1:0] adc_m, sbc_m, inc_m, dec_m;
	logic          adc_c;
	logic [8:0]    adc_bin;
	logic [4:0]    adc_lo5;
	logic [5:0]    adc_lo6;
	logic          adc_hc;
	logic [8:0]    adc_dsum;
	logic [9:0]    adc_dadj;
	logic [DW-1:0] adc_acc;
	logic          adc_c_o, adc_z, adc_n, adc_v;

	logic [8:0]    sbc_bin;
	logic [5:0]    sbc_lo6, sbc_lo26, sbc_lofix;
	logic [10:0]   sbc_hi, sbc_hifix;
	logic [DW-1:0] sbc_acc;

	logic [DW-1:0] cmp_m, and_am, arr_w, arr_wd, ane_v, lxa_v, sbx_t;
	logic [8:0]    cmp_diff, sbx_diff;
	logic [4:0]    arr_lo, arr_hi;
	logic          arr_rc;

	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ane_magic_q <= ANE_MAGIC_RST;
			lxa_magic_q <= LXA_MAGIC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ANE_MAGIC: ane_magic_q <= cfg_wdata;
				CFG_LXA_MAGIC: lxa_magic_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (adv_s2)   vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			op_s1 <= opcode;
			a_s1  <= acc_in;
			x_s1  <= index_x;
			m_s1  <= operand;
			c_s1  <= carry_in;
			d_s1  <= decimal_mode;
			v_s1  <= overflow_in;
		end
		if (adv_s2) begin
			acc_s2 <= r_acc;
			x_s2   <= r_x;
			wb_s2  <= r_wb;
			c_s2   <= r_c;
			z_s2   <= r_z;
			n_s2   <= r_n;
			v_s2   <= r_v;
		end
	end

	// ADC, shared by ADC and RRA
	always_comb begin
		inc_m   = m_s1 + 8'd1;
		dec_m   = m_s1 - 8'd1;
		adc_m   = (op_t'(op_s1) == OP_RRA) ? {c_s1, m_s1[7:1]} : m_s1;
		adc_c   = (op_t'(op_s1) == OP_RRA) ? m_s1[0] : c_s1;
		adc_bin = {1'b0, a_s1} + {1'b0, adc_m} + {8'd0, adc_c};
		adc_lo5 = {1'b0, a_s1[3:0]} + {1'b0, adc_m[3:0]} + {4'd0, adc_c};
		adc_lo6 = (adc_lo5 > 5'd9) ? ({1'b0, adc_lo5} + 6'd6) : {1'b0, adc_lo5};
		adc_hc  = (adc_lo6[5:4] != 2'b00);
		adc_dsum = {1'b0, a_s1[7:4], 4'd0} + {1'b0, adc_m[7:4], 4'd0}
			+ {4'd0, adc_hc, 4'd0} + {5'd0, adc_lo6[3:0]};
		adc_dadj = (adc_dsum > 9'h09F) ? ({1'b0, adc_dsum} + 10'h060) : {1'b0, adc_dsum};
		adc_z    = (adc_bin[7:0] == 8'd0);
		if (d_s1) begin
			adc_n   = adc_dsum[7];
			adc_v   = ~(a_s1[7] ^ adc_m[7]) & (a_s1[7] ^ adc_dsum[7]);
			adc_c_o = (adc_dadj[9:8] != 2'b00);
			adc_acc = adc_dadj[7:0];
		end else begin
			adc_n   = adc_bin[7];
			adc_v   = ~(a_s1[7] ^ adc_m[7]) & (a_s1[7] ^ adc_bin[7]);
			adc_c_o = adc_bin[8];
			adc_acc = adc_bin[7:0];
		end
	end

	// SBC, shared by SBC and ISC; flags always come from the binary difference
	always_comb begin
		sbc_m   = (op_t'(op_s1) == OP_ISC) ? inc_m : m_s1;
		sbc_bin = {1'b0, a_s1} + {1'b0, ~sbc_m} + {8'd0, c_s1};
		sbc_lo6 = {2'b00, a_s1[3:0]} - {2'b00, sbc_m[3:0]} - {5'd0, ~c_s1};
		sbc_lo26 = sbc_lo6 + 6'd26;
		// negative low digit: keep the low nibble of lo+26, then subtract 16
		sbc_lofix = sbc_lo6[5] ? {2'b11, sbc_lo26[3:0]} : sbc_lo6;
		sbc_hi = {3'b000, a_s1[7:4], 4'd0} - {3'b000, sbc_m[7:4], 4'd0}
			+ {{5{sbc_lofix[5]}}, sbc_lofix};
		sbc_hifix = sbc_hi[10] ? (sbc_hi - 11'h060) : sbc_hi;
		sbc_acc   = d_s1 ? sbc_hifix[7:0] : sbc_bin[7:0];
	end

	// compares, ARR, and the magic-constant operations
	always_comb begin
		cmp_m    = (op_t'(op_s1) == OP_DCP) ? dec_m : m_s1;
		cmp_diff = {1'b0, a_s1} - {1'b0, cmp_m};
		and_am   = a_s1 & m_s1;
		sbx_t    = a_s1 & x_s1;
		sbx_diff = {1'b0, sbx_t} - {1'b0, m_s1};
		ane_v    = (a_s1 | ane_magic_q) & x_s1 & m_s1;
		lxa_v    = (a_s1 | lxa_magic_q) & m_s1;
		arr_w    = {c_s1, and_am[7:1]};
		arr_lo   = {1'b0, and_am[3:0]} + {4'd0, and_am[0]};
		arr_hi   = {1'b0, and_am[7:4]} + {4'd0, and_am[4]};
		arr_rc   = (arr_hi > 5'd5);
		arr_wd   = (arr_lo > 5'd5) ? {arr_w[7:4], arr_w[3:0] + 4'd6} : arr_w;
		if (arr_rc) arr_wd = arr_wd + 8'h60;
	end

	always_comb begin
		r_acc = a_s1;
		r_x   = x_s1;
		r_wb  = '0;
		r_c   = c_s1;
		r_v   = v_s1;
		r_z   = (a_s1 == 8'd0);
		r_n   = a_s1[7];
		unique case (op_t'(op_s1))
			OP_ORA: r_acc = a_s1 | m_s1;
			OP_AND, OP_ANC: r_acc = and_am;
			OP_EOR: r_acc = a_s1 ^ m_s1;
			OP_ADC, OP_RRA: begin
				r_acc = adc_acc;
				r_c   = adc_c_o;
				r_v   = adc_v;
			end
			OP_SBC, OP_ISC: begin
				r_acc = sbc_acc;
				r_c   = sbc_bin[8];
				r_v   = (a_s1[7] ^ sbc_m[7]) & (a_s1[7] ^ sbc_bin[7]);
			end
			OP_CMP, OP_DCP: r_c = !cmp_diff[8];
			OP_ASL, OP_SLO: r_c = m_s1[7];
			OP_ROL, OP_RLA: r_c = m_s1[7];
			OP_LSR, OP_SRE, OP_ALR: r_c = (op_t'(op_s1) == OP_ALR) ? and_am[0] : m_s1[0];
			OP_ROR: r_c = m_s1[0];
			OP_ARR: begin
				r_acc = d_s1 ? arr_wd : arr_w;
				r_c   = d_s1 ? arr_rc : and_am[7];
				r_v   = d_s1 ? (and_am[6] ^ arr_w[6]) : (and_am[7] ^ and_am[6]);
			end
			OP_SBX: begin
				r_x = sbx_diff[7:0];
				r_c = !sbx_diff[8];
			end
			OP_ANE: r_acc = ane_v;
			OP_LXA: begin
				r_acc = lxa_v;
				r_x   = lxa_v;
			end
			default: ;
		endcase

		// write-back byte of read-modify-write operations
		case (op_t'(op_s1))
			OP_ASL, OP_SLO: r_wb = {m_s1[6:0], 1'b0};
			OP_LSR, OP_SRE: r_wb = {1'b0, m_s1[7:1]};
			OP_ROL, OP_RLA: r_wb = {m_s1[6:0], c_s1};
			OP_ROR, OP_RRA: r_wb = {c_s1, m_s1[7:1]};
			OP_INC, OP_ISC: r_wb = inc_m;
			OP_DEC, OP_DCP: r_wb = dec_m;
			default: r_wb = '0;
		endcase

		// SLO, RLA and SRE fold the write-back byte into A; ALR shifts A AND operand into A
		case (op_t'(op_s1))
			OP_SLO: r_acc = a_s1 | r_wb;
			OP_RLA: r_acc = a_s1 & r_wb;
			OP_SRE: r_acc = a_s1 ^ r_wb;
			OP_ALR: r_acc = {1'b0, and_am[7:1]};
			default: ;
		endcase

		// N and Z
		case (op_t'(op_s1))
			OP_ADC, OP_RRA: begin
				r_z = adc_z;
				r_n = adc_n;
			end
			OP_SBC, OP_ISC: begin
				r_z = (sbc_bin[7:0] == 8'd0);
				r_n = sbc_bin[7];
			end
			OP_CMP, OP_DCP: begin
				r_z = (cmp_diff[7:0] == 8'd0);
				r_n = cmp_diff[7];
			end
			OP_BIT: begin
				r_z = (and_am == 8'd0);
				r_n = m_s1[7];
			end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
				r_z = (r_wb == 8'd0);
				r_n = r_wb[7];
			end
			OP_SBX: begin
				r_z = (sbx_diff[7:0] == 8'd0);
				r_n = sbx_diff[7];
			end
			OP_ARR: begin
				r_z = (arr_w == 8'd0);
				r_n = d_s1 ? c_s1 : arr_w[7];
			end
			OP_ORA, OP_AND, OP_EOR, OP_ANC, OP_ALR, OP_ANE, OP_LXA,
			OP_SLO, OP_RLA, OP_SRE: begin
				r_z = (r_acc == 8'd0);
				r_n = r_acc[7];
			end
			default: ;
		endcase

		// BIT copies operand bit 6 to V; ANC copies N to C
		if (op_t'(op_s1) == OP_BIT) r_v = m_s1[6];
		if (op_t'(op_s1) == OP_ANC) r_c = r_n;
	end

	assign out_valid    = vld_s2;
	assign acc_out      = acc_s2;
	assign x_out        = x_s2;
	assign write_back   = wb_s2;
	assign carry_out    = c_s2;
	assign zero_out     = z_s2;
	assign negative_out = n_s2;
	assign overflow_out = v_s2;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && !out_ready))
		else $error("in_ready low with a free pipeline slot");

	a_request_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s2) |=> out_valid)
		else $error("request in input register lost on advance");

	a_x_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && vld_s1 && op_s1 != OP_SBX && op_s1 != OP_LXA)
		|=> (x_out == $past(x_s1)))
		else $error("X changed by an operation that leaves it");

	a_wb_zero_logic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && vld_s1 && (op_s1 == OP_ORA || op_s1 == OP_AND || op_s1 == OP_EOR))
		|=> (write_back == 8'd0))
		else $error("write-back byte nonzero for a logic operation");
`endif

endmodule

`default_nettype wire

@@ dv/cpu6502_alu_with_bcd_core_tb.sv @@
// Self-checking testbench for cpu6502_alu_with_bcd_core. It drives requests
// through a queue-fed driver, predicts each result and checks it field by field.
// Depends on c6502alu_pkg and the ALU core RTL.

module cpu6502_alu_with_bcd_core_tb;
	import c6502alu_pkg::*;

	localparam int unsigned OP_CODE_MAX      = (1 << OP_W) - 1;
	localparam int unsigned PHASE_ITEMS      = 300;
	localparam int unsigned NUM_PHASES       = 6;
	localparam int unsigned LONG_HOLD_CYCLES = 200;
	localparam int unsigned PRESSURE_PHASE   = 4;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [DW-1:0]   acc;
		logic [DW-1:0]   idx;
		logic [DW-1:0]   mem;
		logic            c;
		logic            d;
		logic            v;
	} alu_req_t;

	typedef struct packed {
		logic [DW-1:0] acc;
		logic [DW-1:0] idx;
		logic [DW-1:0] wb;
		logic          c;
		logic          z;
		logic          n;
		logic          v;
	} alu_res_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	logic [OP_W-1:0]  opcode       = '0;
	logic [DW-1:0]    acc_in       = '0;
	logic [DW-1:0]    index_x      = '0;
	logic [DW-1:0]    operand      = '0;
	logic             carry_in     = 1'b0;
	logic             decimal_mode = 1'b0;
	logic             overflow_in  = 1'b0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	logic [DW-1:0]    acc_out;
	logic [DW-1:0]    x_out;
	logic [DW-1:0]    write_back;
	logic             carry_out;
	logic             zero_out;
	logic             negative_out;
	logic             overflow_out;
	logic             cfg_we       = 1'b0;
	logic [CFG_W-1:0] cfg_index    = '0;
	logic [DW-1:0]    cfg_wdata    = '0;

	alu_req_t    req_pending_q[$];
	alu_res_t    alu_expected_q[$];
	alu_req_t    offered_req;
	logic [DW-1:0] ane_magic_q = ANE_MAGIC_RST;
	logic [DW-1:0] lxa_magic_q = LXA_MAGIC_RST;
	int unsigned req_total       = 0;
	int unsigned result_count    = 0;
	int unsigned mismatch_count  = 0;
	int unsigned send_idle_pct   = 0;
	int unsigned recv_stall_pct  = 0;
	logic        long_hold_req   = 1'b0;
	logic        long_hold_armed = 1'b0;
	int unsigned long_hold_left  = 0;

	cpu6502_alu_with_bcd_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.acc_in       (acc_in),
		.index_x      (index_x),
		.operand      (operand),
		.carry_in     (carry_in),
		.decimal_mode (decimal_mode),
		.overflow_in  (overflow_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.acc_out      (acc_out),
		.x_out        (x_out),
		.write_back   (write_back),
		.carry_out    (carry_out),
		.zero_out     (zero_out),
		.negative_out (negative_out),
		.overflow_out (overflow_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void set_nz(inout alu_res_t r, input logic [DW-1:0] val);
		r.z = (val == '0);
		r.n = val[DW-1];
	endfunction

	function automatic void add_into(inout alu_res_t r, input int unsigned a, m,
			input logic c, d);
		int unsigned sum;
		int unsigned lo;
		sum = a + m + c;
		if (d) begin
			// Z from the binary sum, N and V after the low digit fix, C after the high one
			lo = (a & 'h0F) + (m & 'h0F) + c;
			r.z = (sum[7:0] == 8'h00);
			if (lo > 'h09) lo += 'h06;
			sum = (a & 'hF0) + (m & 'hF0) + ((lo > 'h0F) ? 'h10 : 0) + (lo & 'h0F);
			r.n = sum[7];
			r.v = ((~(a ^ m) & (a ^ sum) & 'h80) != 0);
			if (sum > 'h9F) sum += 'h60;
		end else begin
			set_nz(r, sum[7:0]);
			r.v = ((~(a ^ m) & (a ^ sum) & 'h80) != 0);
		end
		r.c = (sum > 'hFF);
		r.acc = sum[7:0];
	endfunction

	function automatic void sub_into(inout alu_res_t r, input int unsigned a, m,
			input logic c, d);
		int unsigned diff;
		int lo;
		int hi;
		// flags always come from the binary difference
		diff = a + (~m & 'hFF) + c;
		set_nz(r, diff[7:0]);
		r.v = (((a ^ m) & (a ^ diff) & 'h80) != 0);
		r.c = (diff > 'hFF);
		if (d) begin
			lo = int'(a & 'h0F) - int'(m & 'h0F) - (c ? 0 : 1);
			if (lo < 0) lo = ((lo + 26) & 'h0F) - 'h10;
			hi = int'(a & 'hF0) - int'(m & 'hF0) + lo;
			if (hi < 0) hi -= 'h60;
			r.acc = 8'(hi);
		end else begin
			r.acc = diff[7:0];
		end
	endfunction

	function automatic alu_res_t alu_predict(alu_req_t q);
		alu_res_t      r;
		logic [DW-1:0] t;
		logic [DW-1:0] w;
		int unsigned   hi;
		int unsigned   lo;
		r = '{acc: q.acc, idx: q.idx, wb: '0, c: q.c, z: 1'b0, n: 1'b0, v: q.v};
		set_nz(r, q.acc);
		case (q.op)
			OP_ORA: begin r.acc = q.acc | q.mem; set_nz(r, r.acc); end
			OP_AND: begin r.acc = q.acc & q.mem; set_nz(r, r.acc); end
			OP_EOR: begin r.acc = q.acc ^ q.mem; set_nz(r, r.acc); end
			OP_ADC: add_into(r, 32'(q.acc), 32'(q.mem), q.c, q.d);
			OP_SBC: sub_into(r, 32'(q.acc), 32'(q.mem), q.c, q.d);
			OP_CMP: begin
				r.c = (q.acc >= q.mem);
				set_nz(r, q.acc - q.mem);
			end
			OP_BIT: begin
				r.z = ((q.acc & q.mem) == '0);
				r.n = q.mem[7];
				r.v = q.mem[6];
			end
			OP_ASL: begin r.c = q.mem[7]; r.wb = {q.mem[6:0], 1'b0}; set_nz(r, r.wb); end
			OP_LSR: begin r.c = q.mem[0]; r.wb = {1'b0, q.mem[7:1]}; set_nz(r, r.wb); end
			OP_ROL: begin r.c = q.mem[7]; r.wb = {q.mem[6:0], q.c}; set_nz(r, r.wb); end
			OP_ROR: begin r.c = q.mem[0]; r.wb = {q.c, q.mem[7:1]}; set_nz(r, r.wb); end
			OP_INC: begin r.wb = q.mem + 8'd1; set_nz(r, r.wb); end
			OP_DEC: begin r.wb = q.mem - 8'd1; set_nz(r, r.wb); end
			OP_ANC: begin r.acc = q.acc & q.mem; set_nz(r, r.acc); r.c = r.n; end
			OP_ALR: begin
				t = q.acc & q.mem;
				r.c = t[0];
				r.acc = t >> 1;
				set_nz(r, r.acc);
			end
			OP_ARR: begin
				t = q.acc & q.mem;
				w = {q.c, t[7:1]};
				if (q.d) begin
					hi = 32'(t[7:4]);
					lo = 32'(t[3:0]);
					r.n = q.c;
					r.z = (w == '0);
					r.v = t[6] ^ w[6];
					if (lo + (lo & 1) > 5) w = {w[7:4], 4'(w[3:0] + 4'd6)};
					r.c = (hi + (hi & 1) > 5);
					if (r.c) w = w + 8'h60;
				end else begin
					r.v = t[7] ^ t[6];
					r.c = t[7];
					set_nz(r, w);
				end
				r.acc = w;
			end
			OP_SBX: begin
				t = q.acc & q.idx;
				r.c = (t >= q.mem);
				r.idx = t - q.mem;
				set_nz(r, r.idx);
			end
			OP_ANE: begin r.acc = (q.acc | ane_magic_q) & q.idx & q.mem; set_nz(r, r.acc); end
			OP_LXA: begin
				r.acc = (q.acc | lxa_magic_q) & q.mem;
				r.idx = r.acc;
				set_nz(r, r.acc);
			end
			OP_SLO: begin
				r.c = q.mem[7];
				r.wb = {q.mem[6:0], 1'b0};
				r.acc = q.acc | r.wb;
				set_nz(r, r.acc);
			end
			OP_RLA: begin
				r.c = q.mem[7];
				r.wb = {q.mem[6:0], q.c};
				r.acc = q.acc & r.wb;
				set_nz(r, r.acc);
			end
			OP_SRE: begin
				r.c = q.mem[0];
				r.wb = {1'b0, q.mem[7:1]};
				r.acc = q.acc ^ r.wb;
				set_nz(r, r.acc);
			end
			OP_RRA: begin
				w = {q.c, q.mem[7:1]};
				r.wb = w;
				add_into(r, 32'(q.acc), 32'(w), q.mem[0], q.d);
			end
			OP_DCP: begin
				w = q.mem - 8'd1;
				r.wb = w;
				r.c = (q.acc >= w);
				set_nz(r, q.acc - w);
			end
			OP_ISC: begin
				w = q.mem + 8'd1;
				r.wb = w;
				sub_into(r, 32'(q.acc), 32'(w), q.c, q.d);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [DW-1:0] pick_byte();
		logic [DW-1:0] corners [9] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF,
			8'h99, 8'h0F, 8'hF0};
		case ($urandom_range(9))
			0, 1: return corners[$urandom_range(8)];
			2, 3: return {4'($urandom_range(9)), 4'($urandom_range(9))};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic alu_req_t random_req();
		alu_req_t q;
		if ($urandom_range(99) < 4) q.op = 5'($urandom_range(OP_CODE_MAX, int'(OP_ISC) + 1));
		else q.op = 5'($urandom_range(int'(OP_ISC), int'(OP_ORA)));
		q.acc = pick_byte();
		q.idx = pick_byte();
		q.mem = pick_byte();
		q.c = 1'($urandom);
		q.d = 1'($urandom);
		q.v = 1'($urandom);
		// accumulator form of the shifts passes A in as the operand
		if (q.op inside {OP_ASL, OP_LSR, OP_ROL, OP_ROR} && $urandom_range(2) == 0)
			q.mem = q.acc;
		return q;
	endfunction

	function automatic void queue_req(alu_req_t q);
		req_pending_q.push_back(q);
		req_total++;
	endfunction

	function automatic void queue_op(logic [OP_W-1:0] op, logic [DW-1:0] a, x, m,
			logic c, d, v);
		queue_req('{op: op, acc: a, idx: x, mem: m, c: c, d: d, v: v});
	endfunction

	task automatic write_magic(logic [CFG_W-1:0] index, logic [DW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		if (index == CFG_ANE_MAGIC) ane_magic_q = value;
		else lxa_magic_q = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (result_count < req_total) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_field(string name, logic [DW-1:0] want, got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		mismatch_count++;
	endtask

	// Request driver: predict on acceptance, then offer the next pending request
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) alu_expected_q.push_back(alu_predict(offered_req));
			if (!in_valid || in_ready) begin
				if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = req_pending_q.pop_front();
					in_valid <= 1'b1;
					opcode <= offered_req.op;
					acc_in <= offered_req.acc;
					index_x <= offered_req.idx;
					operand <= offered_req.mem;
					carry_in <= offered_req.c;
					decimal_mode <= offered_req.d;
					overflow_in <= offered_req.v;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure
	always @(posedge clk) begin
		alu_res_t want;
		alu_res_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				got = '{acc: acc_out, idx: x_out, wb: write_back, c: carry_out,
					z: zero_out, n: negative_out, v: overflow_out};
				if (alu_expected_q.size() == 0) begin
					$display("%0t: result with no request pending, actual %0h", $time, got);
					mismatch_count++;
				end else begin
					want = alu_expected_q.pop_front();
					if (got.acc !== want.acc) report_field("acc_out", want.acc, got.acc);
					if (got.idx !== want.idx) report_field("x_out", want.idx, got.idx);
					if (got.wb !== want.wb) report_field("write_back", want.wb, got.wb);
					if (got.c !== want.c) report_field("carry_out", 8'(want.c), 8'(got.c));
					if (got.z !== want.z) report_field("zero_out", 8'(want.z), 8'(got.z));
					if (got.n !== want.n)
						report_field("negative_out", 8'(want.n), 8'(got.n));
					if (got.v !== want.v)
						report_field("overflow_out", 8'(want.v), 8'(got.v));
				end
			end
			if (long_hold_req && !long_hold_armed) begin
				long_hold_armed = 1'b1;
				long_hold_left = LONG_HOLD_CYCLES;
			end
			// hold off long enough for the pipeline to fill and stall the input
			if (long_hold_left != 0) begin
				long_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int unsigned   send_tbl [NUM_PHASES] = '{0, 59, 0, 15, 0, 15};
		int unsigned   recv_tbl [NUM_PHASES] = '{0, 0, 59, 15, 0, 15};
		logic [DW-1:0] ane_tbl  [NUM_PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
		logic [DW-1:0] lxa_tbl  [NUM_PHASES] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset values of both magic constants
		queue_op(OP_ORA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		queue_op(OP_AND, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
		queue_op(OP_EOR, 8'h80, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b1);
		queue_op(OP_ADC, 8'h7F, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0);
		queue_op(OP_SBC, 8'h80, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
		queue_op(OP_CMP, 8'h40, 8'h00, 8'h40, 1'b0, 1'b0, 1'b1);
		queue_op(OP_CMP, 8'h10, 8'h00, 8'h20, 1'b1, 1'b0, 1'b0);
		queue_op(OP_BIT, 8'h3F, 8'h00, 8'hC0, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ASL, 8'h80, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0);
		queue_op(OP_LSR, 8'h55, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ROL, 8'h80, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
		queue_op(OP_ROR, 8'h01, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
		queue_op(OP_INC, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_DEC, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ANC, 8'h80, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ALR, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ARR, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
		queue_op(OP_ARR, 8'hC0, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_SBX, 8'hFF, 8'h0F, 8'h10, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ANE, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_LXA, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_SLO, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_RLA, 8'hFF, 8'h00, 8'h7F, 1'b1, 1'b0, 1'b0);
		queue_op(OP_SRE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		queue_op(OP_RRA, 8'h99, 8'h00, 8'h02, 1'b0, 1'b1, 1'b0);
		queue_op(OP_DCP, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		queue_op(OP_ISC, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
		queue_op(OP_ADC, 8'h99, 8'h00, 8'h01, 1'b0, 1'b1, 1'b0);
		queue_op(OP_SBC, 8'h00, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
		queue_op(5'(OP_CODE_MAX), 8'h80, 8'h5A, 8'hFF, 1'b1, 1'b1, 1'b1);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_magic(CFG_ANE_MAGIC, (p == 2 || p == 3) ? 8'($urandom) : ane_tbl[p]);
			write_magic(CFG_LXA_MAGIC, (p == 2 || p == 3) ? 8'($urandom) : lxa_tbl[p]);
			send_idle_pct = send_tbl[p];
			recv_stall_pct = recv_tbl[p];
			if (p == PRESSURE_PHASE) long_hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) queue_req(random_req());
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
